[src/scfp_pkg.sv]
package scfp_pkg;

   localparam int BYTE_W    = 8;
   localparam int PAT_BYTES = 8;
   localparam int PAT_W     = BYTE_W * PAT_BYTES;
   localparam int PIDX_W    = $clog2(PAT_BYTES);
   localparam int LEN_W     = 4;
   localparam int OUT_W     = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES  = 1'd1;

   localparam logic signed [OUT_W-1:0] NO_POSITION = '1;

endpackage

[src/substring_count_first_position.sv]
// channel   direction  handshake              payload
// req       in         push / full            req_text_byte, req_last_byte
// rsp       out        empty / pop            rsp_match_count, rsp_first_position
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// one text byte per cycle while full is low; the pattern compare over the window is combinational
// a result reaches rsp from its last byte through the item queue, then the result queue
// reset clears the queues, the counters and the pattern registers; no clearing pass
// a stalled rsp side fills the two-entry result queue, then the byte queue, then full rises
module substring_count_first_position
   import scfp_pkg::*;
#(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_TEXT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [BYTE_W-1:0]       req_text_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [OUT_W-1:0]        rsp_match_count,
   output logic signed [OUT_W-1:0] rsp_first_position,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [PAT_W-1:0]        csr_data
);

   localparam int IW = $clog2(MAX_TEXT + 1);
   localparam int QW = 2 + 2 * IW;
   localparam int RW = 2 * OUT_W;

   logic [LEN_W-1:0] pattern_length_ff;
   logic [PAT_W-1:0] pattern_bytes_ff;

   logic             accept;
   logic             cls_hit, cls_last;
   logic [IW-1:0]    cls_start, cls_next;
   logic [QW-1:0]    q_din, q_dout;
   logic             q_empty, q_pop;
   logic             res_full, res_push;
   logic [OUT_W-1:0] res_count;
   logic signed [OUT_W-1:0] res_position;
   logic [RW-1:0]    r_dout;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_bytes_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_W-1:0];
            CSR_PATTERN_BYTES:  pattern_bytes_ff  <= csr_data;
         endcase
      end
   end

   scfp_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_TEXT    (MAX_TEXT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .text_byte      (req_text_byte),
      .last_byte      (req_last_byte),
      .pattern_length (pattern_length_ff),
      .pattern_bytes  (pattern_bytes_ff),
      .cls_hit        (cls_hit),
      .cls_last       (cls_last),
      .cls_start      (cls_start),
      .cls_next       (cls_next)
   );

   assign q_din = {cls_hit, cls_last, cls_start, cls_next};

   scfp_fifo #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (q_din),
      .full  (req_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   scfp_back #(
      .MAX_TEXT (MAX_TEXT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_hit        (q_dout[QW-1]),
      .q_last       (q_dout[QW-2]),
      .q_start      (q_dout[2*IW-1:IW]),
      .q_next       (q_dout[IW-1:0]),
      .res_full     (res_full),
      .res_push     (res_push),
      .res_count    (res_count),
      .res_position (res_position)
   );

   scfp_fifo #(
      .WIDTH (RW),
      .DEPTH (2)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   ({res_count, res_position}),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (r_dout),
      .empty (rsp_empty)
   );

   assign rsp_match_count    = r_dout[RW-1:OUT_W];
   assign rsp_first_position = signed'(r_dout[OUT_W-1:0]);

endmodule

[src/scfp_fifo.sv]
module scfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + AW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + AW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = (AW+1)'(count_ff + (AW+1)'(1));
      end else if (do_pop && !do_push) begin
         count_in = (AW+1)'(count_ff - (AW+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

[src/scfp_front.sv]
module scfp_front
   import scfp_pkg::*;
#(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_TEXT = 4096,
   localparam int IW = $clog2(MAX_TEXT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic              last_byte,
   input  logic [LEN_W-1:0]  pattern_length,
   input  logic [PAT_W-1:0]  pattern_bytes,
   output logic              cls_hit,
   output logic              cls_last,
   output logic [IW-1:0]     cls_start,
   output logic [IW-1:0]     cls_next
);

   logic [BYTE_W-1:0] window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] window_in [MAX_PATTERN];
   logic [IW-1:0]     byte_index_ff, byte_index_in;
   logic              in_range;
   logic              len_ok;
   logic              all_eq;

   assign in_range = (byte_index_ff < IW'(MAX_TEXT));
   assign cls_next = IW'(byte_index_ff + IW'(1));
   assign cls_start = IW'(cls_next - IW'(pattern_length));
   assign len_ok = (pattern_length != '0) &&
                   (pattern_length <= LEN_W'(MAX_PATTERN)) &&
                   (cls_next >= IW'(pattern_length));
   assign cls_hit  = in_range && len_ok && all_eq;
   assign cls_last = last_byte;

   // window slot j holds text byte (newest - j), matched against pattern byte len-1-j
   always_comb begin
      logic [LEN_W-1:0]  pidx;
      logic [PIDX_W-1:0] psel;
      pidx = '0;
      psel = '0;
      all_eq = 1'b1;
      window_in[0] = text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (LEN_W'(j) < pattern_length) begin
            pidx = LEN_W'(pattern_length - LEN_W'(1) - LEN_W'(j));
            psel = pidx[PIDX_W-1:0];
            if (window_in[j] != pattern_bytes[{psel, 3'b000} +: BYTE_W]) begin
               all_eq = 1'b0;
            end
         end
      end
   end

   always_comb begin
      byte_index_in = byte_index_ff;
      if (accept) begin
         if (last_byte) begin
            byte_index_in = '0;
         end else if (in_range) begin
            byte_index_in = cls_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_range) begin
         window_ff <= window_in;
      end
   end

endmodule

[src/scfp_back.sv]
module scfp_back
   import scfp_pkg::*;
#(
   parameter int MAX_TEXT = 4096,
   localparam int IW = $clog2(MAX_TEXT + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic                    q_hit,
   input  logic                    q_last,
   input  logic [IW-1:0]           q_start,
   input  logic [IW-1:0]           q_next,
   input  logic                    res_full,
   output logic                    res_push,
   output logic [OUT_W-1:0]        res_count,
   output logic signed [OUT_W-1:0] res_position
);

   logic [IW-1:0] count_ff, count_in;
   logic [IW-1:0] first_ff, first_in;
   logic [IW-1:0] earliest_ff, earliest_in;
   logic          any_ff, any_in;
   logic          counted;

   // a last item waits for room in the result queue, others always drain
   assign q_pop   = !q_empty && (!q_last || !res_full);
   assign counted = q_hit && (q_start >= earliest_ff);

   always_comb begin
      count_in    = count_ff;
      first_in    = first_ff;
      earliest_in = earliest_ff;
      any_in      = any_ff;
      if (counted) begin
         if (count_ff < IW'(MAX_TEXT)) begin
            count_in = IW'(count_ff + IW'(1));
         end
         if (!any_ff) begin
            first_in = q_start;
         end
         any_in      = 1'b1;
         earliest_in = q_next;
      end
   end

   assign res_push     = q_pop && q_last;
   assign res_count    = OUT_W'(count_in);
   assign res_position = any_in ? signed'(OUT_W'(first_in)) : NO_POSITION;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         first_ff    <= '0;
         earliest_ff <= '0;
         any_ff      <= 1'b0;
      end else if (q_pop) begin
         if (q_last) begin
            count_ff    <= '0;
            first_ff    <= '0;
            earliest_ff <= '0;
            any_ff      <= 1'b0;
         end else begin
            count_ff    <= count_in;
            first_ff    <= first_in;
            earliest_ff <= earliest_in;
            any_ff      <= any_in;
         end
      end
   end

endmodule

[src/scfp_chk.sv]
module scfp_chk
   import scfp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_full,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input logic [OUT_W-1:0]        rsp_match_count,
   input logic signed [OUT_W-1:0] rsp_first_position
);

   // nothing is pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_match_count) && $stable(rsp_first_position)))
      else $error("waiting result changed");

   // no position exactly when nothing was counted
   a_none_pairs: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_match_count == '0) == (rsp_first_position == NO_POSITION)))
      else $error("count and position disagree");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_match_count <= OUT_W'(4096)))
      else $error("count beyond text length");

endmodule

bind substring_count_first_position scfp_chk u_scfp_chk (.*);
